// ===== src/rpa_pkg.sv =====
// Package for the rotating port allocator: codes, reset values and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rpa_pkg;

  localparam int unsigned PORT_W          = 16;
  localparam int unsigned SPAN_W          = 17;
  localparam int unsigned MAP_ENTRIES_DEF = 4096;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;

  localparam logic [PORT_W-1:0] RANGE_LOW_RST  = 16'd49152;
  localparam logic [PORT_W-1:0] RANGE_HIGH_RST = 16'd53247;
  localparam logic [PORT_W-1:0] CURSOR_RST     = RANGE_LOW_RST - 16'd1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    OP_ANY        = 3'd0,
    OP_EVEN       = 3'd1,
    OP_PAIR       = 3'd2,
    OP_CLAIM_FREE = 3'd3,
    OP_CLAIM_RESV = 3'd4,
    OP_FREE       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MS_FREE  = 2'd0,
    MS_ALLOC = 2'd1,
    MS_RESV  = 2'd2
  } map_state_t;

  // Effective range derived from the configuration registers.
  typedef struct packed {
    logic [PORT_W-1:0] lo;    // low bound, zero taken as one
    logic [SPAN_W-1:0] span;  // number of ports in the clamped range
  } cfg_eff_t;

endpackage
`default_nettype wire

// ===== src/rpa_map_ram.sv =====
// Port state memory for both transports: one write port, two registered read ports.
// Depends on rpa_pkg for the entry type.
`default_nettype none
module rpa_map_ram #(
  parameter int unsigned ADDR_W = 13
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [ADDR_W-1:0]       wr_addr,
  input  wire rpa_pkg::map_state_t     wr_data,
  input  wire logic [ADDR_W-1:0]       rd0_addr,
  input  wire logic [ADDR_W-1:0]       rd1_addr,
  output rpa_pkg::map_state_t          rd0_data,
  output rpa_pkg::map_state_t          rd1_data
);
  import rpa_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  map_state_t mem [DEPTH];
  map_state_t rd0_r;
  map_state_t rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem[rd0_addr];
    rd1_r <= mem[rd1_addr];
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule
`default_nettype wire

// ===== src/rpa_cfg_regs.sv =====
// APB register file holding the range bounds, plus the registered effective range.
// Depends on rpa_pkg for reset values, register indexes and the range struct.
`default_nettype none
module rpa_cfg_regs #(
  parameter int unsigned MAP_ENTRIES = rpa_pkg::MAP_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rpa_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rpa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [rpa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output rpa_pkg::cfg_eff_t                     eff
);
  import rpa_pkg::*;

  logic [PORT_W-1:0] range_low_r,  range_low_nxt;
  logic [PORT_W-1:0] range_high_r, range_high_nxt;
  cfg_eff_t          eff_r, eff_nxt;

  logic              wr_fire;
  logic [PORT_W-1:0] lo_eff;
  logic [SPAN_W-1:0] cap;
  logic [SPAN_W-1:0] hi_clamp;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_comb begin
    range_low_nxt  = range_low_r;
    range_high_nxt = range_high_r;
    if (wr_fire) begin
      case (paddr[2])
        REG_RANGE_LOW:  range_low_nxt  = pwdata[PORT_W-1:0];
        REG_RANGE_HIGH: range_high_nxt = pwdata[PORT_W-1:0];
        default:        range_low_nxt  = range_low_r;
      endcase
    end
  end

  // Clamp the top to the map size and turn the bounds into a span.
  always_comb begin
    lo_eff   = (range_low_r == '0) ? PORT_W'(1) : range_low_r;
    cap      = SPAN_W'(lo_eff) + SPAN_W'(MAP_ENTRIES - 1);
    hi_clamp = (SPAN_W'(range_high_r) > cap) ? cap : SPAN_W'(range_high_r);
    eff_nxt.lo   = lo_eff;
    eff_nxt.span = (hi_clamp < SPAN_W'(lo_eff)) ? '0
                                                : hi_clamp - SPAN_W'(lo_eff) + SPAN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      eff_r.lo     <= RANGE_LOW_RST;
      eff_r.span   <= SPAN_W'(RANGE_HIGH_RST) - SPAN_W'(RANGE_LOW_RST) + SPAN_W'(1);
    end else begin
      range_low_r  <= range_low_nxt;
      range_high_r <= range_high_nxt;
      eff_r        <= eff_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RANGE_LOW:  prdata = APB_DATA_W'(range_low_r);
      REG_RANGE_HIGH: prdata = APB_DATA_W'(range_high_r);
      default:        prdata = '0;
    endcase
  end

  assign eff = eff_r;

endmodule
`default_nettype wire

// ===== src/rpa_ctrl.sv =====
// Sequencer of the allocator: clearing pass, map scan, claims, frees and result register.
// Depends on rpa_pkg; drives the ports of rpa_map_ram.
`default_nettype none
module rpa_ctrl #(
  parameter int unsigned MAP_ENTRIES = rpa_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned ADDR_W      = $clog2(MAP_ENTRIES) + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_opcode,
  input  wire logic                         in_tcp,
  input  wire logic [rpa_pkg::PORT_W-1:0]   in_port,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [rpa_pkg::PORT_W-1:0]   out_port,
  output logic                              out_ok,
  input  wire rpa_pkg::cfg_eff_t            eff,
  output logic                              wr_en,
  output logic      [ADDR_W-1:0]            wr_addr,
  output rpa_pkg::map_state_t               wr_data,
  output logic      [ADDR_W-1:0]            rd0_addr,
  output logic      [ADDR_W-1:0]            rd1_addr,
  input  wire rpa_pkg::map_state_t          rd0_data,
  input  wire rpa_pkg::map_state_t          rd1_data
);
  import rpa_pkg::*;

  localparam int unsigned OFF_W = ADDR_W - 1;
  localparam int unsigned CNT_W = $clog2(MAP_ENTRIES + 1);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_PREP   = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_PAIR   = 9'b000010000,
    ST_CLAIM  = 9'b000100000,
    ST_FREE   = 9'b001000000,
    ST_FREE2  = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [PORT_W-1:0]   cur_udp_r, cur_udp_nxt;
  logic [PORT_W-1:0]   cur_tcp_r, cur_tcp_nxt;
  logic                pv_r, pv_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [2:0]          op_r, op_nxt;
  logic                tcp_r, tcp_nxt;
  logic [PORT_W-1:0]   port_r, port_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [OFF_W-1:0]    poff_r, poff_nxt;
  logic                pelig_r, pelig_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                have_first_r, have_first_nxt;
  logic [PORT_W-1:0]   first_r, first_nxt;
  logic [PORT_W-1:0]   res_port_r, res_port_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [PORT_W-1:0]   out_port_r, out_port_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic [PORT_W-1:0]   lo;
  logic [CNT_W-1:0]    n;
  logic [PORT_W-1:0]   cur;
  logic [SPAN_W-1:0]   cur_rel;
  logic [SPAN_W-1:0]   s_raw;
  logic                cur_in;
  logic [OFF_W-1:0]    start_off;
  logic [SPAN_W-1:0]   port_rel;
  logic                port_in;
  logic [CNT_W-1:0]    off_inc;
  logic [OFF_W-1:0]    off_wrap;
  logic                elig;
  logic                hit;
  logic                scan_end;
  logic [PORT_W-1:0]   p_chk;
  logic                is_search;
  logic                free_upper;
  map_state_t          want;
  logic                cur_wr;
  logic [PORT_W-1:0]   cur_val;

  assign lo        = eff.lo;
  assign n         = CNT_W'(eff.span);
  assign cur       = tcp_r ? cur_tcp_r : cur_udp_r;
  assign is_search = (op_r == OP_ANY) || (op_r == OP_EVEN) || (op_r == OP_PAIR);

  // Where a search starts and whether the requested port lies in the range.
  always_comb begin
    cur_rel   = SPAN_W'(cur) - SPAN_W'(lo);
    s_raw     = cur_rel + SPAN_W'(1);
    cur_in    = (cur >= lo) && (cur_rel < SPAN_W'(n));
    start_off = (cur_in && (s_raw < SPAN_W'(n))) ? OFF_W'(s_raw) : '0;
    port_rel  = SPAN_W'(port_r) - SPAN_W'(lo);
    port_in   = (n != '0) && (port_r >= lo) && (port_rel < SPAN_W'(n));
  end

  // The shared step unit: next offset with wraparound and its eligibility.
  always_comb begin
    off_inc  = CNT_W'(off_r) + CNT_W'(1);
    off_wrap = (off_inc == n) ? '0 : OFF_W'(off_inc);
    elig     = ((op_r == OP_ANY) || ((lo[0] ^ off_r[0]) == 1'b0)) &&
               ((op_r != OP_PAIR) || (off_inc < n));
    p_chk    = lo + PORT_W'(poff_r);
    hit      = pv_r && pelig_r && (rd0_data == MS_FREE) &&
               ((op_r != OP_PAIR) || (rd1_data == MS_FREE));
    scan_end = !pv_r && (cnt_r == n);
    want     = (op_r == OP_CLAIM_FREE) ? MS_FREE : MS_RESV;
    free_upper = !port_r[0] && (off_inc < n) && (rd1_data == MS_RESV);
  end

  always_comb begin
    if (state_r == ST_PREP) begin
      rd0_addr = {tcp_r, OFF_W'(port_rel)};
      rd1_addr = {tcp_r, OFF_W'(port_rel + SPAN_W'(1))};
    end else begin
      rd0_addr = {tcp_r, off_r};
      rd1_addr = {tcp_r, OFF_W'(off_inc)};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    pv_nxt         = pv_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    tcp_nxt        = tcp_r;
    port_nxt       = port_r;
    off_nxt        = off_r;
    poff_nxt       = poff_r;
    pelig_nxt      = pelig_r;
    cnt_nxt        = cnt_r;
    have_first_nxt = have_first_r;
    first_nxt      = first_r;
    res_port_nxt   = res_port_r;
    res_ok_nxt     = res_ok_r;
    out_port_nxt   = out_port_r;
    out_ok_nxt     = out_ok_r;
    cur_wr         = 1'b0;
    cur_val        = cur;
    wr_en          = 1'b0;
    wr_addr        = {tcp_r, off_r};
    wr_data        = MS_FREE;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          tcp_nxt   = in_tcp;
          port_nxt  = in_port;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        res_port_nxt = '0;
        res_ok_nxt   = 1'b0;
        off_nxt      = OFF_W'(port_rel);
        state_nxt    = ST_RESULT;
        case (op_r)
          OP_ANY, OP_EVEN, OP_PAIR: begin
            if (n != '0) begin
              off_nxt        = start_off;
              cnt_nxt        = '0;
              pv_nxt         = 1'b0;
              have_first_nxt = 1'b0;
              state_nxt      = ST_SCAN;
            end
          end
          OP_CLAIM_FREE, OP_CLAIM_RESV: begin
            if (port_in) begin
              state_nxt = ST_CLAIM;
            end
          end
          OP_FREE: begin
            if (port_in) begin
              state_nxt = ST_FREE;
            end
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        // Issue a probe of the current offset while checking the previous one.
        if (cnt_r != n) begin
          pv_nxt    = 1'b1;
          poff_nxt  = off_r;
          pelig_nxt = elig;
          off_nxt   = off_wrap;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && pelig_r && !have_first_r) begin
          have_first_nxt = 1'b1;
          first_nxt      = p_chk;
        end
        if (hit) begin
          wr_en        = 1'b1;
          wr_addr      = {tcp_r, poff_r};
          wr_data      = MS_ALLOC;
          cur_wr       = 1'b1;
          cur_val      = p_chk;
          res_port_nxt = p_chk;
          res_ok_nxt   = 1'b1;
          pv_nxt       = 1'b0;
          off_nxt      = OFF_W'(CNT_W'(poff_r) + CNT_W'(1));
          state_nxt    = (op_r == OP_PAIR) ? ST_PAIR : ST_RESULT;
        end else if (scan_end) begin
          cur_wr    = have_first_r;
          cur_val   = first_r;
          state_nxt = ST_RESULT;
        end
      end
      ST_PAIR: begin
        wr_en     = 1'b1;
        wr_data   = MS_RESV;
        state_nxt = ST_RESULT;
      end
      ST_CLAIM: begin
        if (rd0_data == want) begin
          wr_en        = 1'b1;
          wr_data      = MS_ALLOC;
          res_port_nxt = port_r;
          res_ok_nxt   = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_FREE: begin
        wr_en      = 1'b1;
        wr_data    = MS_FREE;
        res_ok_nxt = 1'b1;
        if (free_upper) begin
          off_nxt   = OFF_W'(off_inc);
          state_nxt = ST_FREE2;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_FREE2: begin
        wr_en     = 1'b1;
        wr_data   = MS_FREE;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_port_nxt  = res_port_r;
          out_ok_nxt    = res_ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    cur_udp_nxt = (cur_wr && !tcp_r) ? cur_val : cur_udp_r;
    cur_tcp_nxt = (cur_wr && tcp_r)  ? cur_val : cur_tcp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cur_udp_r   <= CURSOR_RST;
      cur_tcp_r   <= CURSOR_RST;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_udp_r   <= cur_udp_nxt;
      cur_tcp_r   <= cur_tcp_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tcp_r        <= tcp_nxt;
    port_r       <= port_nxt;
    off_r        <= off_nxt;
    poff_r       <= poff_nxt;
    pelig_r      <= pelig_nxt;
    cnt_r        <= cnt_nxt;
    have_first_r <= have_first_nxt;
    first_r      <= first_nxt;
    res_port_r   <= res_port_nxt;
    res_ok_r     <= res_ok_nxt;
    out_port_r   <= out_port_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_port  = out_port_r;
  assign out_ok    = out_ok_r;

`ifndef SYNTHESIS
  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PREP))
    else $error("accepted item did not enter preparation");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= n))
    else $error("scan probed more entries than the range holds");

  a_scan_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r == ST_SCAN)) |-> (wr_data == MS_ALLOC))
    else $error("scan hit wrote something other than allocated");

  a_search_port_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESULT) && res_ok_r && is_search) |-> (res_port_r != '0))
    else $error("successful search reported port zero");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!in_ready && !out_valid_r))
    else $error("item handshake active during clearing pass");
`endif

endmodule
`default_nettype wire

// ===== src/rotating_port_allocator_top.sv =====
// Top level of the rotating port allocator: stream channels, APB registers, map memory.
// Depends on rpa_pkg, rpa_cfg_regs, rpa_map_ram and rpa_ctrl.
//
// Usage. Each input item is a request on the in_ channel: an opcode (allocate any,
// allocate even, allocate even pair, claim free, claim reserved, free), the transport
// in in_tuser, and a port for claims and frees. Every item yields exactly one result
// item on the out_ channel: the port handed out or claimed (zero when none) in
// out_tdata and the success flag in out_tuser. The range bounds are to be set through
// the APB port while the block is idle, which the block itself does not enforce; the
// maps keep their entries across such writes. Sequence: an accepted claim or free in
// range passes through PREP, CLAIM or FREE, and RESULT; a free that also releases its
// reserved neighbor adds FREE2; an out-of-range claim or free and an undefined opcode
// go from PREP straight to RESULT. A search probes one map entry per cycle through a
// single step unit and one memory read port pair, up to span entries (span = number
// of ports in the clamped range, up to MAP_ENTRIES), and ends early on a free entry.
// One item is worked on at a time; in_tready is high only in the idle state.
// Reset. rst_n is synchronous and active low. After reset the block runs a clearing
// pass over all 2 * 2^ceil(log2(MAP_ENTRIES)) map memory entries (8192 at the default
// size), one entry per cycle; in_tready stays low meanwhile, while register
// writes are taken as ever. Both cursors reset to the default low bound minus one.
// Stalls. The result sits in an output register; a new item may be accepted while it
// waits, and that item's result is held inside until out_tready frees the register.
`default_nettype none
module rotating_port_allocator_top #(
  parameter int unsigned MAP_ENTRIES = rpa_pkg::MAP_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: opcode [2:0], port [18:3], zero padding [23:19]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [23:0]                      in_tdata,
  // in_tuser: transport_tcp [0]
  input  wire logic                             in_tuser,
  // out_tdata: port_out [15:0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [15:0]                      out_tdata,
  // out_tuser: success [0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [rpa_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [rpa_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic      [rpa_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);
  import rpa_pkg::*;

  // One address bit selects the transport, the rest index the entry offset.
  localparam int unsigned ADDR_W = $clog2(MAP_ENTRIES) + 1;

  cfg_eff_t            eff;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  map_state_t          wr_data;
  logic [ADDR_W-1:0]   rd0_addr;
  logic [ADDR_W-1:0]   rd1_addr;
  map_state_t          rd0_data;
  map_state_t          rd1_data;

  rpa_cfg_regs #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .eff     (eff)
  );

  rpa_map_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

  rpa_ctrl #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tdata[2:0]),
    .in_tcp    (in_tuser),
    .in_port   (in_tdata[18:3]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_port  (out_tdata),
    .out_ok    (out_tuser),
    .eff       (eff),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd0_addr  (rd0_addr),
    .rd1_addr  (rd1_addr),
    .rd0_data  (rd0_data),
    .rd1_data  (rd1_data)
  );

endmodule
`default_nettype wire
